// ----- sv/vrc4_pkg.sv -----
// ----------------------------------------------------------------------------
// vrc4_pkg
// word types, register addresses and update codes for the vrc4 bank and irq
// mapper
// ----------------------------------------------------------------------------
`default_nettype none

package vrc4_pkg;

    typedef struct packed {
        logic        cmd;
        logic [15:0] address;
        logic [7:0]  data;
        logic [6:0]  cycles;
    } in_word_t;

    typedef struct packed {
        logic [1:0] update_kind;
        logic [2:0] update_slot;
        logic [7:0] update_value;
        logic       irq_line;
    } out_word_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_PRG    = 2'd1;
    localparam logic [1:0] KIND_CHR    = 2'd2;
    localparam logic [1:0] KIND_MIRROR = 2'd3;

    localparam logic [15:0] ADDR_MASK = 16'hF0CF;

    localparam logic [15:0] ADDR_PRG_A   = 16'h8000;
    localparam logic [15:0] ADDR_PRG_B   = 16'hA000;
    localparam logic [15:0] ADDR_MIRROR  = 16'h9000;
    localparam logic [15:0] ADDR_SWAP_0  = 16'h9002;
    localparam logic [15:0] ADDR_SWAP_1  = 16'h9080;
    localparam logic [15:0] ADDR_LATCH_L = 16'hF000;
    localparam logic [15:0] ADDR_LATCH_H0 = 16'hF002;
    localparam logic [15:0] ADDR_LATCH_H1 = 16'hF040;
    localparam logic [15:0] ADDR_ACK_0   = 16'hF003;
    localparam logic [15:0] ADDR_ACK_1   = 16'hF0C0;
    localparam logic [15:0] ADDR_ACK_2   = 16'hF006;
    localparam logic [15:0] ADDR_CTRL_0  = 16'hF004;
    localparam logic [15:0] ADDR_CTRL_1  = 16'hF080;

    localparam logic [3:0] CHR_PAGE_FIRST = 4'hB;
    localparam logic [3:0] CHR_PAGE_LAST  = 4'hE;

    localparam logic [2:0] PRG_SLOT_A = 3'd4;
    localparam logic [2:0] PRG_SLOT_B = 3'd5;
    localparam logic [2:0] PRG_SLOT_C = 3'd6;

    localparam logic [6:0] PRESCALE_PERIOD = 7'd114;
    localparam logic [7:0] COUNT_MAX       = 8'hFF;

endpackage

`default_nettype wire

// ----- sv/vrc4_bank_and_irq_mapper_top.sv -----
// ----------------------------------------------------------------------------
// vrc4_bank_and_irq_mapper_top
// decodes cpu writes into prg, chr and mirroring updates and runs the
// prescaled irq counter on tick words
// ----------------------------------------------------------------------------
// from input accept to result valid a word passes the input register, then the result register
// throughput: one word per cycle when out_ready allows; state is updated as a word
//   leaves the input register, so the next word sees it at once
// reset: asynchronous, active low; chr bank entry i reads i, other control and irq state 0, word registers not reset
`default_nettype none

module vrc4_bank_and_irq_mapper_top
    import vrc4_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_word
);

    logic      s1_valid_reg;
    in_word_t  s1_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    logic      s1_adv;

    logic [7:0] chr_bank_reg [8];
    logic [7:0] chr_bank_next [8];
    logic [7:0] swap_mode_reg, swap_mode_next;
    logic [1:0] irq_control_reg, irq_control_next;
    logic [7:0] irq_count_reg, irq_count_next;
    logic [7:0] irq_reload_reg, irq_reload_next;
    logic [6:0] prescale_reg, prescale_next;
    logic       irq_reg, irq_next;
    out_word_t  res;

    logic [15:0] addr_m;
    logic [7:0]  dat;
    logic [6:0]  cyc;
    logic        chr_page;
    logic        chr_hit;
    logic        chr_sub;
    logic        chr_high;
    logic [3:0]  page_off;
    logic [2:0]  chr_idx;
    logic [7:0]  chr_old;
    logic [7:0]  chr_new;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // address decode
    always_comb
    begin
        addr_m   = s1_word_reg.address & ADDR_MASK;
        dat      = s1_word_reg.data;
        cyc      = (s1_word_reg.cycles > PRESCALE_PERIOD) ? PRESCALE_PERIOD
                                                          : s1_word_reg.cycles;
        chr_page = addr_m[15:12] inside {[CHR_PAGE_FIRST:CHR_PAGE_LAST]};
        chr_hit  = 1'b1;
        chr_sub  = 1'b0;
        chr_high = 1'b0;
        case (addr_m[7:0])
            8'h00:
            begin
                chr_sub  = 1'b0;
                chr_high = 1'b0;
            end
            8'h02, 8'h40:
            begin
                chr_sub  = 1'b0;
                chr_high = 1'b1;
            end
            8'h01, 8'h04, 8'h80:
            begin
                chr_sub  = 1'b1;
                chr_high = 1'b0;
            end
            8'h03, 8'h06, 8'hC0:
            begin
                chr_sub  = 1'b1;
                chr_high = 1'b1;
            end
            default:
            begin
                chr_hit = 1'b0;
            end
        endcase
        page_off = addr_m[15:12] - CHR_PAGE_FIRST;
        chr_idx  = {page_off[1:0], chr_sub};
        chr_old  = chr_bank_reg[chr_idx];
        chr_new  = chr_high ? {dat[3:0], chr_old[3:0]} : {chr_old[7:4], dat[3:0]};
    end

    // next state and result
    always_comb
    begin
        chr_bank_next    = chr_bank_reg;
        swap_mode_next   = swap_mode_reg;
        irq_control_next = irq_control_reg;
        irq_count_next   = irq_count_reg;
        irq_reload_next  = irq_reload_reg;
        prescale_next    = prescale_reg;
        irq_next         = irq_reg;
        res              = '0;

        if (s1_word_reg.cmd == CMD_TICK)
        begin
            if (irq_control_reg[1])
            begin
                if (prescale_reg < cyc)
                begin
                    prescale_next = prescale_reg + PRESCALE_PERIOD - cyc;
                    if (irq_count_reg == COUNT_MAX)
                    begin
                        irq_count_next = irq_reload_reg;
                        irq_next       = 1'b1;
                    end
                    else
                    begin
                        irq_count_next = irq_count_reg + 8'd1;
                    end
                end
                else
                begin
                    prescale_next = prescale_reg - cyc;
                end
            end
        end
        else if (addr_m == ADDR_PRG_A)
        begin
            res.update_kind  = KIND_PRG;
            res.update_slot  = swap_mode_reg[1] ? PRG_SLOT_C : PRG_SLOT_A;
            res.update_value = dat;
        end
        else if (addr_m == ADDR_PRG_B)
        begin
            res.update_kind  = KIND_PRG;
            res.update_slot  = PRG_SLOT_B;
            res.update_value = dat;
        end
        else if (addr_m == ADDR_MIRROR)
        begin
            res.update_kind  = KIND_MIRROR;
            res.update_value = {6'd0, dat[1:0]};
        end
        else if (addr_m inside {ADDR_SWAP_0, ADDR_SWAP_1})
        begin
            swap_mode_next = dat;
        end
        else if (chr_page)
        begin
            if (chr_hit)
            begin
                chr_bank_next[chr_idx] = chr_new;
                res.update_kind        = KIND_CHR;
                res.update_slot        = chr_idx;
                res.update_value       = chr_new;
            end
        end
        else if (addr_m == ADDR_LATCH_L)
        begin
            irq_reload_next = {irq_reload_reg[7:4], dat[3:0]};
        end
        else if (addr_m inside {ADDR_LATCH_H0, ADDR_LATCH_H1})
        begin
            irq_reload_next = {dat[3:0], irq_reload_reg[3:0]};
        end
        else if (addr_m inside {ADDR_ACK_0, ADDR_ACK_1, ADDR_ACK_2})
        begin
            irq_control_next = {2{irq_control_reg[0]}};
            prescale_next    = '0;
            irq_next         = 1'b0;
        end
        else if (addr_m inside {ADDR_CTRL_0, ADDR_CTRL_1})
        begin
            irq_control_next = dat[1:0];
            if (dat[1])
            begin
                irq_count_next = irq_reload_reg;
                prescale_next  = '0;
            end
            irq_next = 1'b0;
        end

        res.irq_line = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            swap_mode_reg   <= '0;
            irq_control_reg <= '0;
            irq_count_reg   <= '0;
            irq_reload_reg  <= '0;
            prescale_reg    <= '0;
            irq_reg         <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chr_bank_reg[i] <= 8'(i);
            end
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg   <= 1'b1;
                chr_bank_reg    <= chr_bank_next;
                swap_mode_reg   <= swap_mode_next;
                irq_control_reg <= irq_control_next;
                irq_count_reg   <= irq_count_next;
                irq_reload_reg  <= irq_reload_next;
                prescale_reg    <= prescale_next;
                irq_reg         <= irq_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_word_reg <= in_word;
        end
        if (s1_adv)
        begin
            out_word_reg <= res;
        end
    end

    // checks
    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.update_kind == KIND_NONE) |->
        (out_word_reg.update_slot == 3'd0 && out_word_reg.update_value == 8'd0))
        else $error("empty update carries slot or value");

    a_prg_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.update_kind == KIND_PRG) |->
        (out_word_reg.update_slot == PRG_SLOT_A || out_word_reg.update_slot == PRG_SLOT_B
         || out_word_reg.update_slot == PRG_SLOT_C))
        else $error("prg update to bad slot");

    a_mirror_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.update_kind == KIND_MIRROR) |->
        (out_word_reg.update_slot == 3'd0 && out_word_reg.update_value[7:2] == 6'd0))
        else $error("mirroring update out of range");

    a_irq_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(irq_reg) |-> $past(s1_adv && s1_word_reg.cmd == CMD_WRITE))
        else $error("irq dropped without a cpu write");

    a_irq_matches: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (out_word_reg.irq_line == irq_reg))
        else $error("result irq level differs from irq state");

    a_prescale_range: assert property (@(posedge clk) disable iff (!rst_n)
        prescale_reg < PRESCALE_PERIOD)
        else $error("prescaler out of range");

endmodule

`default_nettype wire

// ----- tb/vrc4_bank_and_irq_mapper_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrc4_bank_and_irq_mapper_top_tb
// drives cpu write and tick words into the mapper and checks every result
// word, in order, against an in-bench model of the bank registers, the
// address aliases and the prescaled irq counter. directed words cover the
// register extremes and aliases, then random words and irq counting runs
// follow under random sender gaps, receiver stalls and one long output hold
// ----------------------------------------------------------------------------

module vrc4_bank_and_irq_mapper_top_tb;

    import vrc4_pkg::*;

    localparam int unsigned HOLD_LEN       = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned SETTLE_CYCLES  = 4;

    // low address byte codes inside a chr page
    localparam logic [7:0] CHR_A_LO   = 8'h00;
    localparam logic [7:0] CHR_A_HI_0 = 8'h02;
    localparam logic [7:0] CHR_A_HI_1 = 8'h40;
    localparam logic [7:0] CHR_B_LO_0 = 8'h01;
    localparam logic [7:0] CHR_B_LO_1 = 8'h04;
    localparam logic [7:0] CHR_B_LO_2 = 8'h80;
    localparam logic [7:0] CHR_B_HI_0 = 8'h03;
    localparam logic [7:0] CHR_B_HI_1 = 8'h06;
    localparam logic [7:0] CHR_B_HI_2 = 8'hC0;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    // mapper model state
    logic [7:0] chr_bank [8];
    logic [7:0] swap_reg;
    logic [1:0] irq_ctrl;
    logic [7:0] irq_cnt;
    logic [7:0] irq_reload;
    logic [6:0] prescale_cnt;
    logic       irq_pending;

    out_word_t   pending_results [$];
    out_word_t   head_word;
    int unsigned words_sent       = 0;
    int unsigned results_seen     = 0;
    int unsigned mismatches       = 0;
    int unsigned prg_updates      = 0;
    int unsigned chr_updates      = 0;
    int unsigned mirror_updates   = 0;
    int unsigned quiet_results    = 0;
    int unsigned irq_high_results = 0;
    int unsigned burst_left       = 0;

    int unsigned hold_token  = 0;
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;
    int unsigned ready_pct   = 100;
    logic [6:0]  rx_phase    = '0;
    int unsigned quiet_count = 0;

    vrc4_bank_and_irq_mapper_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] with_nibble(input logic [7:0] old, input logic [7:0] d,
                                               input logic upper);
        return upper ? {d[3:0], old[3:0]} : {old[7:4], d[3:0]};
    endfunction

    function automatic out_word_t mapper_apply(input in_word_t w);
        out_word_t  r;
        logic [15:0] a;
        logic [3:0]  page;
        logic [7:0]  sel;
        logic [6:0]  cyc;
        logic        hit;
        logic        upper;
        logic        sub;
        logic [2:0]  idx;
        r     = '0;
        hit   = 1'b0;
        upper = 1'b0;
        sub   = 1'b0;
        if (w.cmd == CMD_TICK)
        begin
            cyc = (w.cycles > PRESCALE_PERIOD) ? PRESCALE_PERIOD : w.cycles;
            if (irq_ctrl[1])
            begin
                if (prescale_cnt < cyc)
                begin
                    prescale_cnt = prescale_cnt + PRESCALE_PERIOD - cyc;
                    if (irq_cnt == COUNT_MAX)
                    begin
                        irq_cnt     = irq_reload;
                        irq_pending = 1'b1;
                    end
                    else
                    begin
                        irq_cnt = irq_cnt + 8'd1;
                    end
                end
                else
                begin
                    prescale_cnt = prescale_cnt - cyc;
                end
            end
        end
        else
        begin
            a    = w.address & ADDR_MASK;
            page = a[15:12];
            sel  = a[7:0];
            if (a == ADDR_PRG_A)
            begin
                r.update_kind  = KIND_PRG;
                r.update_slot  = swap_reg[1] ? PRG_SLOT_C : PRG_SLOT_A;
                r.update_value = w.data;
            end
            else if (a == ADDR_PRG_B)
            begin
                r.update_kind  = KIND_PRG;
                r.update_slot  = PRG_SLOT_B;
                r.update_value = w.data;
            end
            else if (a == ADDR_MIRROR)
            begin
                r.update_kind  = KIND_MIRROR;
                r.update_value = {6'd0, w.data[1:0]};
            end
            else if (a == ADDR_SWAP_0 || a == ADDR_SWAP_1)
            begin
                swap_reg = w.data;
            end
            else if (page >= CHR_PAGE_FIRST && page <= CHR_PAGE_LAST)
            begin
                case (sel)
                    CHR_A_LO:
                    begin
                        hit = 1'b1;
                    end
                    CHR_A_HI_0, CHR_A_HI_1:
                    begin
                        hit   = 1'b1;
                        upper = 1'b1;
                    end
                    CHR_B_LO_0, CHR_B_LO_1, CHR_B_LO_2:
                    begin
                        hit = 1'b1;
                        sub = 1'b1;
                    end
                    CHR_B_HI_0, CHR_B_HI_1, CHR_B_HI_2:
                    begin
                        hit   = 1'b1;
                        sub   = 1'b1;
                        upper = 1'b1;
                    end
                    default:
                    begin
                        hit = 1'b0;
                    end
                endcase
                if (hit)
                begin
                    idx            = {2'(page - CHR_PAGE_FIRST), sub};
                    chr_bank[idx]  = with_nibble(chr_bank[idx], w.data, upper);
                    r.update_kind  = KIND_CHR;
                    r.update_slot  = idx;
                    r.update_value = chr_bank[idx];
                end
            end
            else if (a == ADDR_LATCH_L)
            begin
                irq_reload = with_nibble(irq_reload, w.data, 1'b0);
            end
            else if (a == ADDR_LATCH_H0 || a == ADDR_LATCH_H1)
            begin
                irq_reload = with_nibble(irq_reload, w.data, 1'b1);
            end
            else if (a == ADDR_ACK_0 || a == ADDR_ACK_1 || a == ADDR_ACK_2)
            begin
                irq_ctrl     = irq_ctrl[0] ? 2'b11 : 2'b00;
                prescale_cnt = '0;
                irq_pending  = 1'b0;
            end
            else if (a == ADDR_CTRL_0 || a == ADDR_CTRL_1)
            begin
                irq_ctrl = w.data[1:0];
                if (irq_ctrl[1])
                begin
                    irq_cnt      = irq_reload;
                    prescale_cnt = '0;
                end
                irq_pending = 1'b0;
            end
        end
        r.irq_line = irq_pending;
        return r;
    endfunction

    function automatic in_word_t make_write(input logic [15:0] addr, input logic [7:0] d);
        in_word_t w;
        w.cmd     = CMD_WRITE;
        w.address = addr;
        w.data    = d;
        w.cycles  = 7'($urandom);
        return w;
    endfunction

    function automatic in_word_t make_tick(input logic [6:0] cyc);
        in_word_t w;
        w.cmd     = CMD_TICK;
        w.address = 16'($urandom);
        w.data    = 8'($urandom);
        w.cycles  = cyc;
        return w;
    endfunction

    // set the address bits the decoder ignores
    function automatic logic [15:0] scatter(input logic [15:0] base);
        return base | (16'($urandom) & ~ADDR_MASK);
    endfunction

    function automatic in_word_t random_word();
        int unsigned pick;
        logic [15:0] base;
        logic [7:0]  sel;
        logic [7:0]  d;
        pick = $urandom_range(0, 99);
        d    = 8'($urandom);
        base = '0;
        sel  = '0;
        if (pick < 30)
        begin
            if ($urandom_range(0, 3) != 0)
                return make_tick(7'($urandom_range(80, 114)));
            return make_tick(7'($urandom));
        end
        else if (pick < 38)
            base = ADDR_PRG_A;
        else if (pick < 43)
            base = ADDR_PRG_B;
        else if (pick < 48)
            base = ADDR_MIRROR;
        else if (pick < 53)
            base = $urandom_range(0, 1) ? ADDR_SWAP_0 : ADDR_SWAP_1;
        else if (pick < 73)
        begin
            case ($urandom_range(0, 8))
                0:       sel = CHR_A_LO;
                1:       sel = CHR_A_HI_0;
                2:       sel = CHR_A_HI_1;
                3:       sel = CHR_B_LO_0;
                4:       sel = CHR_B_LO_1;
                5:       sel = CHR_B_LO_2;
                6:       sel = CHR_B_HI_0;
                7:       sel = CHR_B_HI_1;
                default: sel = CHR_B_HI_2;
            endcase
            base = {4'($urandom_range(CHR_PAGE_FIRST, CHR_PAGE_LAST)), 4'h0, sel};
        end
        else if (pick < 80)
        begin
            case ($urandom_range(0, 2))
                0:       base = ADDR_LATCH_L;
                1:       base = ADDR_LATCH_H0;
                default: base = ADDR_LATCH_H1;
            endcase
        end
        else if (pick < 85)
        begin
            base = $urandom_range(0, 1) ? ADDR_CTRL_0 : ADDR_CTRL_1;
            if ($urandom_range(0, 2) != 0)
                d = d | 8'h02;
        end
        else if (pick < 90)
        begin
            case ($urandom_range(0, 2))
                0:       base = ADDR_ACK_0;
                1:       base = ADDR_ACK_1;
                default: base = ADDR_ACK_2;
            endcase
        end
        else
            return make_write(16'($urandom), d);
        return make_write(scatter(base), d);
    endfunction

    task automatic send_word(input in_word_t w);
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(mapper_apply(w));
        words_sent++;
    endtask

    task automatic offer(input in_word_t w);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_word(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // load a latch (mostly near the top), enable counting, tick a random number of times, then ack or rewrite control
    task automatic irq_burst();
        int unsigned ticks;
        logic [7:0]  hi_data;
        hi_data = ($urandom_range(0, 3) != 0) ? {4'($urandom), 4'hF} : 8'($urandom);
        offer(make_write(scatter(ADDR_LATCH_L), 8'($urandom)));
        offer(make_write(scatter($urandom_range(0, 1) ? ADDR_LATCH_H0 : ADDR_LATCH_H1),
                         hi_data));
        offer(make_write(scatter($urandom_range(0, 1) ? ADDR_CTRL_0 : ADDR_CTRL_1),
                         8'($urandom) | 8'h02));
        ticks = $urandom_range(5, 40);
        repeat (ticks)
        begin
            if ($urandom_range(0, 5) == 0)
                offer(random_word());
            else
                offer(make_tick(7'($urandom_range(90, 127))));
        end
        if ($urandom_range(0, 1) != 0)
            offer(make_write(scatter(ADDR_ACK_0), 8'($urandom)));
        else
            offer(make_write(scatter(ADDR_CTRL_1), 8'($urandom)));
    endtask

    task automatic test_bank_writes();
        offer(make_write(ADDR_PRG_A, 8'h00));
        offer(make_write(16'hFFFF, 8'hFF));
        offer(make_write(scatter(ADDR_PRG_B), 8'hFF));
        offer(make_write(ADDR_MIRROR, 8'hFF));
        offer(make_write(ADDR_SWAP_0, 8'h02));
        offer(make_write(scatter(ADDR_PRG_A), 8'hA5));
        offer(make_write(ADDR_SWAP_1, 8'h00));
        offer(make_write(scatter(ADDR_PRG_A), 8'h5A));
    endtask

    task automatic test_chr_writes();
        offer(make_write(scatter({CHR_PAGE_FIRST, 4'h0, CHR_A_LO}), 8'hFF));
        offer(make_write(scatter({CHR_PAGE_FIRST + 4'd1, 4'h0, CHR_A_HI_0}), 8'hFF));
        offer(make_write(scatter({CHR_PAGE_FIRST + 4'd2, 4'h0, CHR_A_HI_1}), 8'h00));
        offer(make_write(scatter({CHR_PAGE_LAST, 4'h0, CHR_B_LO_0}), 8'h3C));
        offer(make_write(scatter({CHR_PAGE_FIRST, 4'h0, CHR_B_LO_1}), 8'h00));
        offer(make_write(scatter({CHR_PAGE_FIRST + 4'd1, 4'h0, CHR_B_LO_2}), 8'hFF));
        offer(make_write(scatter({CHR_PAGE_FIRST + 4'd2, 4'h0, CHR_B_HI_0}), 8'h07));
        offer(make_write(scatter({CHR_PAGE_LAST, 4'h0, CHR_B_HI_1}), 8'hFF));
        offer(make_write(scatter({CHR_PAGE_LAST, 4'h0, CHR_B_HI_2}), 8'h0A));
    endtask

    task automatic test_irq_counter();
        offer(make_tick(PRESCALE_PERIOD));
        offer(make_write(ADDR_LATCH_L, 8'h0E));
        offer(make_write(ADDR_LATCH_H1, 8'hFF));
        offer(make_write(ADDR_CTRL_0, 8'h03));
        offer(make_tick(7'd0));
        offer(make_tick(7'h7F));
        offer(make_tick(PRESCALE_PERIOD));
        offer(make_write(ADDR_MIRROR, 8'h02));
        offer(make_write(ADDR_ACK_0, 8'h00));
        offer(make_write(ADDR_LATCH_H0, 8'h00));
        offer(make_write(ADDR_CTRL_1, 8'h00));
        offer(make_write(ADDR_ACK_1, 8'hFF));
        offer(make_write(ADDR_ACK_2, 8'h00));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                irq_burst();
            else
                offer(random_word());
        end
    endtask

    // receiver holds off while words keep coming, so the input backs up
    task automatic test_output_stall();
        hold_token <= hold_token + 1;
        repeat (48) send_word(random_word());
        burst_left = 0;
    endtask

    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 7'd1;
        if (rx_phase == '0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pct <= 100;
                1:       ready_pct <= 85;
                2:       ready_pct <= 50;
                default: ready_pct <= 20;
            endcase
        end
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_LEN;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word %h with nothing pending", out_word);
            end
            else
            begin
                head_word = pending_results.pop_front();
                if (out_word.update_kind !== head_word.update_kind ||
                    out_word.update_slot !== head_word.update_slot ||
                    out_word.update_value !== head_word.update_value ||
                    out_word.irq_line !== head_word.irq_line)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("result %0d: expected kind %0d slot %0d value %h irq %b",
                                 results_seen, head_word.update_kind, head_word.update_slot,
                                 head_word.update_value, head_word.irq_line);
                        $display("result %0d: got      kind %0d slot %0d value %h irq %b",
                                 results_seen, out_word.update_kind, out_word.update_slot,
                                 out_word.update_value, out_word.irq_line);
                    end
                end
                case (head_word.update_kind)
                    KIND_PRG:    prg_updates++;
                    KIND_CHR:    chr_updates++;
                    KIND_MIRROR: mirror_updates++;
                    default:     quiet_results++;
                endcase
                if (head_word.irq_line)
                    irq_high_results++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
            if (quiet_count >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", quiet_count);
                $display("vrc4_bank_and_irq_mapper_top_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
            chr_bank[i] = 8'(i);
        swap_reg     = '0;
        irq_ctrl     = '0;
        irq_cnt      = '0;
        irq_reload   = '0;
        prescale_cnt = '0;
        irq_pending  = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bank_writes();
        test_chr_writes();
        test_irq_counter();
        drain();
        test_random_traffic(400);
        drain();
        test_output_stall();
        test_random_traffic(330);
        drain();

        $display("%0d words sent, %0d results: %0d prg, %0d chr, %0d mirroring, %0d quiet",
                 words_sent, results_seen, prg_updates, chr_updates, mirror_updates,
                 quiet_results);
        $display("irq line high on %0d results, %0d mismatches",
                 irq_high_results, mismatches);
        if (mismatches == 0)
            $display("vrc4_bank_and_irq_mapper_top_tb: done, clean");
        else
            $display("vrc4_bank_and_irq_mapper_top_tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/vrc4_pkg.sv
sv/vrc4_bank_and_irq_mapper_top.sv
tb/vrc4_bank_and_irq_mapper_top_tb.sv
